FILE: hw/rtl/frd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Frame deframer package
// Types, codes and constants shared by the frame receive deframer.
// ----------------------------------------------------------------------------
package frd_pkg;

	// Input operation codes
	localparam logic [1:0] FUNC_BYTE   = 2'd0;
	localparam logic [1:0] FUNC_FLUSH  = 2'd1;
	localparam logic [1:0] FUNC_CANCEL = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_RECORD  = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_CHANNEL    = 2'd0;
	localparam logic [1:0] REG_NULL_ID    = 2'd1;
	localparam logic [1:0] REG_ID_LIMIT   = 2'd2;
	localparam logic [1:0] REG_MAX_LENGTH = 2'd3;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	// Register reset values
	localparam logic [7:0]  CHANNEL_RST    = 8'd0;
	localparam logic [7:0]  NULL_ID_RST    = 8'd0;
	localparam logic [7:0]  ID_LIMIT_RST   = 8'd255;
	localparam logic [15:0] MAX_LENGTH_RST = 16'd4096;

	// Highest channel number that is not flagged
	localparam logic [7:0] CH_LIMIT = 8'd7;

	// Receiver modes, one-hot
	typedef enum logic [4:0] {
		MODE_ID     = 5'b00001,
		MODE_LEN_LO = 5'b00010,
		MODE_LEN_HI = 5'b00100,
		MODE_DATA   = 5'b01000,
		MODE_ERROR  = 5'b10000
	} rx_mode_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
		logic       sink_ready;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  frame_id;
		logic [7:0]  frame_channel;
		logic [15:0] frame_length;
		logic [15:0] byte_index;
		logic [7:0]  payload;
		logic        err_unknown_id;
		logic        err_bad_channel;
		logic        err_oversize;
		logic        err_underflow;
		logic        last;
	} out_item_t;

	// Frame context carried alongside each payload and record result
	typedef struct packed {
		logic [7:0]  id;
		logic [7:0]  channel;
		logic [15:0] length;
		logic        unknown_id;
		logic        bad_channel;
	} frame_ctx_t;

	// Builds one result; for an end marker it fills in only the kind, payload and the oversize and underflow flags.
	function automatic out_item_t make_result(
		input logic [1:0]  kind,
		input frame_ctx_t  ctx,
		input logic [15:0] index,
		input logic [7:0]  value,
		input logic        oversize,
		input logic        underflow
	);
		out_item_t r;
		r = '0;
		r.kind          = kind;
		r.payload       = value;
		r.err_oversize  = oversize;
		r.err_underflow = underflow;
		if (kind != KIND_END) begin
			r.frame_id        = ctx.id;
			r.frame_channel   = ctx.channel;
			r.frame_length    = ctx.length;
			r.byte_index      = index;
			r.err_unknown_id  = ctx.unknown_id;
			r.err_bad_channel = ctx.bad_channel;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/frame_receive_deframer.sv
`default_nettype none
// Results are registered in the result queue before they are offered.
// Throughput: one input per cycle; an input yields up to two results, which
// leave one per cycle while out_stall is low, through a four-entry result
// queue. Input stalls while fewer than two queue entries are free.
// Reset: configuration takes its reset values, the receiver waits for an ID
// byte and the result queue is empty.
// ----------------------------------------------------------------------------
// Frame receive deframer
// Splits a byte stream into ID, little-endian length and payload, passing
// payload bytes on as they arrive and emitting frame and end-of-packet records.
// ----------------------------------------------------------------------------
module frame_receive_deframer (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [frd_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire [frd_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire frd_pkg::in_item_t              in_data,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output frd_pkg::out_item_t                  out_data
);
	import frd_pkg::*;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Configuration registers
	logic [7:0]  channel_q;
	logic [7:0]  null_id_q;
	logic [7:0]  id_limit_q;
	logic [15:0] max_length_q;

	// Receiver state
	rx_mode_t    mode_q;
	frame_ctx_t  ctx_q;
	logic [15:0] byte_count_q;

	// Result queue
	out_item_t         queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic        in_xfer;
	logic        out_xfer;
	rx_mode_t    mode_d;
	frame_ctx_t  ctx_d;
	logic [15:0] byte_count_d;
	logic [15:0] count_inc;
	logic [15:0] new_length;
	logic [1:0]  num_res;
	out_item_t   res0;
	out_item_t   res1;

	assign in_stall  = count_q > QCNT_W'(QDEPTH - 2);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = count_q != '0;
	assign out_xfer  = out_valid && !out_stall;
	assign out_data  = queue_q[rd_ptr_q];

	assign count_inc  = byte_count_q + 16'd1;
	assign new_length = {in_data.data_byte, ctx_q.length[7:0]};

	always_comb begin
		mode_d       = mode_q;
		ctx_d        = ctx_q;
		byte_count_d = byte_count_q;
		num_res      = 2'd0;
		res0         = '0;
		res1         = '0;
		case (in_data.func)
			FUNC_BYTE: begin
				unique case (mode_q)
					MODE_ID: begin
						if (in_data.data_byte == null_id_q) begin
							mode_d = MODE_ERROR;
						end else begin
							ctx_d.id          = in_data.data_byte;
							ctx_d.channel     = channel_q;
							ctx_d.unknown_id  = in_data.data_byte > id_limit_q;
							ctx_d.bad_channel = channel_q > CH_LIMIT;
							ctx_d.length      = '0;
							byte_count_d      = '0;
							mode_d            = MODE_LEN_LO;
						end
					end
					MODE_LEN_LO: begin
						ctx_d.length = {8'd0, in_data.data_byte};
						mode_d       = MODE_LEN_HI;
					end
					MODE_LEN_HI: begin
						ctx_d.length = new_length;
						byte_count_d = '0;
						if (new_length > max_length_q) begin
							res0   = make_result(KIND_RECORD, ctx_d, '0, '0, 1'b1, 1'b0);
							num_res = in_data.sink_ready ? 2'd1 : 2'd0;
							mode_d = MODE_ERROR;
						end else if (new_length == '0) begin
							res0   = make_result(KIND_RECORD, ctx_d, '0, '0, 1'b0, 1'b0);
							num_res = in_data.sink_ready ? 2'd1 : 2'd0;
							mode_d = MODE_ID;
						end else begin
							mode_d = MODE_DATA;
						end
					end
					MODE_DATA: begin
						res0 = make_result(KIND_PAYLOAD, ctx_q, byte_count_q,
							in_data.data_byte, 1'b0, 1'b0);
						res1 = make_result(KIND_RECORD, ctx_q, count_inc, '0, 1'b0, 1'b0);
						byte_count_d = count_inc;
						num_res      = 2'd1;
						if (count_inc >= ctx_q.length) begin
							mode_d = MODE_ID;
							if (in_data.sink_ready) begin
								num_res = 2'd2;
							end
						end
					end
					MODE_ERROR: begin
						mode_d = MODE_ERROR;
					end
					default: begin
						mode_d = MODE_ID;
					end
				endcase
			end
			FUNC_FLUSH: begin
				mode_d       = MODE_ID;
				byte_count_d = '0;
				if (in_data.sink_ready) begin
					if (mode_q == MODE_DATA) begin
						res0    = make_result(KIND_RECORD, ctx_q, byte_count_q, '0,
							1'b0, 1'b1);
						res1    = make_result(KIND_END, ctx_q, '0, '0, 1'b0, 1'b0);
						num_res = 2'd2;
					end else begin
						res0    = make_result(KIND_END, ctx_q, '0, '0, 1'b0, 1'b0);
						num_res = 2'd1;
					end
				end
			end
			FUNC_CANCEL: begin
				mode_d       = MODE_ID;
				byte_count_d = '0;
			end
			default: begin
				// Unused code: nothing changes.
			end
		endcase
		// Mark the final result of this transfer.
		if (num_res == 2'd1) begin
			res0.last = 1'b1;
		end else if (num_res == 2'd2) begin
			res1.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q    <= CHANNEL_RST;
			null_id_q    <= NULL_ID_RST;
			id_limit_q   <= ID_LIMIT_RST;
			max_length_q <= MAX_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHANNEL:    channel_q    <= cfg_data[7:0];
				REG_NULL_ID:    null_id_q    <= cfg_data[7:0];
				REG_ID_LIMIT:   id_limit_q   <= cfg_data[7:0];
				REG_MAX_LENGTH: max_length_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_ID;
			ctx_q        <= '0;
			byte_count_q <= '0;
		end else if (in_xfer) begin
			mode_q       <= mode_d;
			ctx_q        <= ctx_d;
			byte_count_q <= byte_count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			if (num_res != 2'd0) begin
				queue_q[wr_ptr_q] <= res0;
			end
			if (num_res == 2'd2) begin
				queue_q[wr_ptr_q + QPTR_W'(1)] <= res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_xfer) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(num_res);
			end
			if (out_xfer) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + (in_xfer ? QCNT_W'(num_res) : '0)
				- (out_xfer ? QCNT_W'(1) : '0);
		end
	end

endmodule
`default_nettype wire
